/* hdl/aqac_pkg.sv */
// Shared types and constants for the air-quality alarm controller.
package aqac_pkg;

  typedef enum logic [1:0] {
    MD_AUTO,
    MD_MANUAL,
    MD_THRESH
  } mode_t;

  typedef enum logic [2:0] {
    CMD_SAMPLE,
    CMD_TICK,
    CMD_MODE_KEY,
    CMD_SELECT_KEY,
    CMD_PLUS_KEY,
    CMD_MINUS_KEY
  } cmd_t;

  localparam logic [1:0] DEV_FAN    = 2'd0;
  localparam logic [1:0] DEV_BUZZER = 2'd1;
  localparam logic [1:0] DEV_LIGHT  = 2'd2;

  localparam logic [2:0] LIM_PM25  = 3'd0;
  localparam logic [2:0] LIM_TEMP  = 3'd1;
  localparam logic [2:0] LIM_HUM   = 3'd2;
  localparam logic [2:0] LIM_SMOKE = 3'd3;
  localparam logic [2:0] LIM_CO    = 3'd4;
  localparam int         LIM_COUNT = 5;

  localparam logic [1:0] CFG_HAS_TEMP_HUMIDITY = 2'd0;
  localparam logic [1:0] CFG_HAS_SMOKE         = 2'd1;
  localparam logic [1:0] CFG_HAS_CO            = 2'd2;

  localparam logic [15:0]       PM25_LIMIT_RST  = 16'd100;
  localparam logic signed [7:0] TEMP_LIMIT_RST  = 8'sd35;
  localparam logic [7:0]        HUM_LIMIT_RST   = 8'd80;
  localparam logic [15:0]       SMOKE_LIMIT_RST = 16'd500;
  localparam logic [15:0]       CO_LIMIT_RST    = 16'd50;

  localparam logic [15:0]       PM25_STEP  = 16'd10;
  localparam logic signed [7:0] TEMP_STEP  = 8'sd1;
  localparam logic [7:0]        HUM_STEP   = 8'd5;
  localparam logic [15:0]       SMOKE_STEP = 16'd50;
  localparam logic [15:0]       CO_STEP    = 16'd5;
  localparam logic signed [7:0] TEMP_LIMIT_FLOOR = -8'sd40;

  localparam int IN_DATA_W  = 64;
  localparam int IN_USER_W  = 3;
  localparam int OUT_DATA_W = 32;

  typedef struct packed {
    logic [2:0]        command;
    logic [15:0]       co;
    logic [15:0]       smoke;
    logic [7:0]        humidity;
    logic signed [7:0] temp;
    logic [15:0]       pm25;
  } in_item_t;

  // Packs into the output tdata, fan in bit 0.
  typedef struct packed {
    logic [2:0]         pad;
    logic               telemetry_request;
    logic signed [16:0] limit_value;
    logic [2:0]         limit_selected;
    logic [1:0]         device_selected;
    logic [1:0]         mode_now;
    logic               alarm_hit;
    logic               lamp_on;
    logic               buzz_on;
    logic               fan_on;
  } result_t;

  typedef struct packed {
    logic       valid;
    logic [1:0] index;
    logic       data;
  } cfg_wr_t;

endpackage

/* hdl/air_quality_alarm_controller.sv */
// Top level: input stage, controller core and output register.
// An event is registered in the input stage, the core computes its result, and the output
// register holds that result valid on the output port until it is taken.
// Throughput: one event per cycle while the output is not stalled; the input and
// output registers let a new event enter while a finished result waits to be taken.
// Reset (rst, synchronous, active high) restores default limits, auto mode,
// all devices off, stored readings zero and all sensors marked fitted.
module air_quality_alarm_controller
  import aqac_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // pm25[15:0], temp[23:16], humidity[31:24], smoke[47:32], co[63:48]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // command[2:0]
  input  logic [IN_USER_W-1:0]  s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // fan[0], buzzer[1], light[2], alarm[3], mode[5:4], device[7:6],
  // limit_selected[10:8], limit_value[27:11], telemetry_request[28], zero[31:29]
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic                  cfg_data
);

  logic     item_valid;
  logic     advance;
  in_item_t item;
  result_t  result;
  result_t  out_data;
  logic     out_valid;
  cfg_wr_t  cfg;

  assign cfg_ready = 1'b1;
  assign cfg       = {cfg_valid, cfg_index, cfg_data};

  assign advance = item_valid && (!out_valid || m_axis_tready);

  aqac_in_stage u_in_stage (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .take          (advance),
    .item_valid    (item_valid),
    .item          (item)
  );

  aqac_core u_core (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .step   (advance),
    .item   (item),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= result;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  a_sample_tele: assert property (@(posedge clk) disable iff (rst)
    advance && item.command == CMD_SAMPLE |=> m_axis_tvalid && out_data.telemetry_request)
    else $error("sample event did not raise telemetry request");

  a_tick_outputs: assert property (@(posedge clk) disable iff (rst)
    advance && item.command == CMD_TICK |=>
      out_data.mode_now != MD_AUTO ||
      (out_data.fan_on == out_data.alarm_hit && out_data.buzz_on == out_data.alarm_hit &&
       out_data.lamp_on == out_data.alarm_hit))
    else $error("auto tick left devices out of step with alarm");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !item_valid |-> s_axis_tready)
    else $error("input stalled while input stage empty");

  a_no_result_loss: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |-> !advance)
    else $error("result overwritten while stalled");

endmodule

/* hdl/aqac_in_stage.sv */
// Input register stage: holds one accepted event until the core takes it.
module aqac_in_stage
  import aqac_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [IN_DATA_W-1:0] s_axis_tdata,
  input  logic [IN_USER_W-1:0] s_axis_tuser,
  input  logic                 take,
  output logic                 item_valid,
  output in_item_t             item
);

  logic     full;
  in_item_t data;

  assign s_axis_tready = !full || take;
  assign item_valid    = full;
  assign item          = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (s_axis_tready) begin
      full <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      data.command  <= s_axis_tuser;
      data.pm25     <= s_axis_tdata[15:0];
      data.temp     <= s_axis_tdata[23:16];
      data.humidity <= s_axis_tdata[31:24];
      data.smoke    <= s_axis_tdata[47:32];
      data.co       <= s_axis_tdata[63:48];
    end
  end

endmodule

/* hdl/aqac_core.sv */
// Controller state, sensor-fit registers and the per-event update logic.
module aqac_core
  import aqac_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  cfg_wr_t  cfg,
  input  logic     step,
  input  in_item_t item,
  output result_t  result
);

  logic has_th, has_smoke, has_co;

  mode_t             mode, mode_next;
  logic [1:0]        dev_sel, dev_sel_next;
  logic [2:0]        lim_sel, lim_sel_next;
  logic [15:0]       pm25_limit, pm25_limit_next;
  logic signed [7:0] temp_limit, temp_limit_next;
  logic [7:0]        hum_limit, hum_limit_next;
  logic [15:0]       smoke_limit, smoke_limit_next;
  logic [15:0]       co_limit, co_limit_next;
  logic [15:0]       pm25_val, pm25_val_next;
  logic signed [7:0] temp_val, temp_val_next;
  logic [7:0]        hum_val, hum_val_next;
  logic [15:0]       smoke_val, smoke_val_next;
  logic [15:0]       co_val, co_val_next;
  logic              fan, fan_next;
  logic              buzzer, buzzer_next;
  logic              light, light_next;
  logic              alarm, alarm_next;
  logic              over;

  function automatic logic limit_avail(input logic [2:0] idx, input logic th,
                                       input logic sm, input logic c);
    logic a;
    case (idx)
      LIM_PM25:          a = 1'b1;
      LIM_TEMP, LIM_HUM: a = th;
      LIM_SMOKE:         a = sm;
      LIM_CO:            a = c;
      default:           a = 1'b0;
    endcase
    return a;
  endfunction

  // Walk forward through the limit list to the next fitted sensor.
  function automatic logic [2:0] next_limit(input logic [2:0] cur, input logic th,
                                            input logic sm, input logic c);
    logic [2:0] n;
    logic       found;
    n     = cur;
    found = 1'b0;
    for (int k = 0; k < LIM_COUNT; k++) begin
      if (!found) begin
        n     = (n >= LIM_CO) ? LIM_PM25 : n + 3'd1;
        found = limit_avail(n, th, sm, c);
      end
    end
    return found ? n : LIM_PM25;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      has_th    <= 1'b1;
      has_smoke <= 1'b1;
      has_co    <= 1'b1;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_HAS_TEMP_HUMIDITY: has_th    <= cfg.data;
        CFG_HAS_SMOKE:         has_smoke <= cfg.data;
        CFG_HAS_CO:            has_co    <= cfg.data;
        default: ;
      endcase
    end
  end

  assign over = (pm25_val > pm25_limit)
              || (has_th && (temp_val > temp_limit))
              || (has_th && (hum_val > hum_limit))
              || (has_smoke && (smoke_val > smoke_limit))
              || (has_co && (co_val > co_limit));

  always_comb begin
    mode_next        = mode;
    dev_sel_next     = dev_sel;
    lim_sel_next     = lim_sel;
    pm25_limit_next  = pm25_limit;
    temp_limit_next  = temp_limit;
    hum_limit_next   = hum_limit;
    smoke_limit_next = smoke_limit;
    co_limit_next    = co_limit;
    pm25_val_next    = pm25_val;
    temp_val_next    = temp_val;
    hum_val_next     = hum_val;
    smoke_val_next   = smoke_val;
    co_val_next      = co_val;
    fan_next         = fan;
    buzzer_next      = buzzer;
    light_next       = light;
    alarm_next       = alarm;
    if (step) begin
      case (item.command)
        CMD_SAMPLE: begin
          pm25_val_next = item.pm25;
          if (has_th) begin
            temp_val_next = item.temp;
            hum_val_next  = item.humidity;
          end
          if (has_smoke) smoke_val_next = item.smoke;
          if (has_co) co_val_next = item.co;
        end
        CMD_TICK: begin
          if (mode == MD_AUTO) begin
            alarm_next  = over;
            fan_next    = over;
            buzzer_next = over;
            light_next  = over;
          end
        end
        CMD_MODE_KEY: begin
          case (mode)
            MD_AUTO: begin
              mode_next    = MD_MANUAL;
              dev_sel_next = DEV_FAN;
            end
            MD_MANUAL: begin
              mode_next    = MD_THRESH;
              lim_sel_next = LIM_PM25;
            end
            default: mode_next = MD_AUTO;
          endcase
        end
        CMD_SELECT_KEY: begin
          if (mode == MD_MANUAL) begin
            dev_sel_next = (dev_sel >= DEV_LIGHT) ? DEV_FAN : dev_sel + 2'd1;
          end else if (mode == MD_THRESH) begin
            lim_sel_next = next_limit(lim_sel, has_th, has_smoke, has_co);
          end
        end
        CMD_PLUS_KEY: begin
          if (mode == MD_MANUAL) begin
            case (dev_sel)
              DEV_FAN:    fan_next    = 1'b1;
              DEV_BUZZER: buzzer_next = 1'b1;
              DEV_LIGHT:  light_next  = 1'b1;
              default: ;
            endcase
          end else if (mode == MD_THRESH) begin
            // all increments wrap within the limit width
            case (lim_sel)
              LIM_PM25:  pm25_limit_next  = pm25_limit + PM25_STEP;
              LIM_TEMP:  temp_limit_next  = temp_limit + TEMP_STEP;
              LIM_HUM:   hum_limit_next   = hum_limit + HUM_STEP;
              LIM_SMOKE: smoke_limit_next = smoke_limit + SMOKE_STEP;
              LIM_CO:    co_limit_next    = co_limit + CO_STEP;
              default: ;
            endcase
          end
        end
        CMD_MINUS_KEY: begin
          if (mode == MD_MANUAL) begin
            case (dev_sel)
              DEV_FAN:    fan_next    = 1'b0;
              DEV_BUZZER: buzzer_next = 1'b0;
              DEV_LIGHT:  light_next  = 1'b0;
              default: ;
            endcase
          end else if (mode == MD_THRESH) begin
            case (lim_sel)
              LIM_PM25:
                if (pm25_limit >= PM25_STEP) pm25_limit_next = pm25_limit - PM25_STEP;
              LIM_TEMP:
                if (temp_limit > TEMP_LIMIT_FLOOR) temp_limit_next = temp_limit - TEMP_STEP;
              LIM_HUM:
                if (hum_limit >= HUM_STEP) hum_limit_next = hum_limit - HUM_STEP;
              LIM_SMOKE:
                if (smoke_limit >= SMOKE_STEP) smoke_limit_next = smoke_limit - SMOKE_STEP;
              LIM_CO:
                if (co_limit >= CO_STEP) co_limit_next = co_limit - CO_STEP;
              default: ;
            endcase
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MD_AUTO;
      dev_sel     <= DEV_FAN;
      lim_sel     <= LIM_PM25;
      pm25_limit  <= PM25_LIMIT_RST;
      temp_limit  <= TEMP_LIMIT_RST;
      hum_limit   <= HUM_LIMIT_RST;
      smoke_limit <= SMOKE_LIMIT_RST;
      co_limit    <= CO_LIMIT_RST;
      pm25_val    <= '0;
      temp_val    <= '0;
      hum_val     <= '0;
      smoke_val   <= '0;
      co_val      <= '0;
      fan         <= 1'b0;
      buzzer      <= 1'b0;
      light       <= 1'b0;
      alarm       <= 1'b0;
    end else begin
      mode        <= mode_next;
      dev_sel     <= dev_sel_next;
      lim_sel     <= lim_sel_next;
      pm25_limit  <= pm25_limit_next;
      temp_limit  <= temp_limit_next;
      hum_limit   <= hum_limit_next;
      smoke_limit <= smoke_limit_next;
      co_limit    <= co_limit_next;
      pm25_val    <= pm25_val_next;
      temp_val    <= temp_val_next;
      hum_val     <= hum_val_next;
      smoke_val   <= smoke_val_next;
      co_val      <= co_val_next;
      fan         <= fan_next;
      buzzer      <= buzzer_next;
      light       <= light_next;
      alarm       <= alarm_next;
    end
  end

  // Result reflects the state after this event.
  always_comb begin
    result                   = '0;
    result.fan_on            = fan_next;
    result.buzz_on           = buzzer_next;
    result.lamp_on           = light_next;
    result.alarm_hit         = alarm_next;
    result.mode_now          = mode_next;
    result.device_selected   = dev_sel_next;
    result.limit_selected    = lim_sel_next;
    result.telemetry_request = (item.command == CMD_SAMPLE);
    case (lim_sel_next)
      LIM_PM25:  result.limit_value = {1'b0, pm25_limit_next};
      LIM_TEMP:  result.limit_value = {{9{temp_limit_next[7]}}, temp_limit_next};
      LIM_HUM:   result.limit_value = {9'd0, hum_limit_next};
      LIM_SMOKE: result.limit_value = {1'b0, smoke_limit_next};
      LIM_CO:    result.limit_value = {1'b0, co_limit_next};
      default:   result.limit_value = '0;
    endcase
  end

endmodule

/* bench/aqac_status_checker.sv */
// Watches the controller's event, status and register channels and checks every status word.
module aqac_status_checker
  import aqac_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  input  logic [IN_USER_W-1:0]  s_axis_tuser,
  input  logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  input  logic [OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic                  cfg_data,
  output int                    mismatches,
  output int                    pending
);

  // sensor fit flags
  logic has_th, has_smoke, has_co;

  // controller state as the block should hold it
  mode_t             mode;
  logic [1:0]        dev_sel;
  logic [2:0]        lim_sel;
  logic [15:0]       pm25_lim, smoke_lim, co_lim;
  logic signed [7:0] temp_lim;
  logic [7:0]        hum_lim;
  logic [15:0]       pm25_rd, smoke_rd, co_rd;
  logic signed [7:0] temp_rd;
  logic [7:0]        hum_rd;
  logic              fan, buzzer, light, alarm;

  result_t status_q[$];

  function automatic logic limit_fitted(input logic [2:0] idx);
    case (idx)
      LIM_PM25:          return 1'b1;
      LIM_TEMP, LIM_HUM: return has_th;
      LIM_SMOKE:         return has_smoke;
      LIM_CO:            return has_co;
      default:           return 1'b0;
    endcase
  endfunction

  function automatic logic signed [16:0] selected_limit();
    case (lim_sel)
      LIM_PM25:  return {1'b0, pm25_lim};
      LIM_TEMP:  return {{9{temp_lim[7]}}, temp_lim};
      LIM_HUM:   return {9'd0, hum_lim};
      LIM_SMOKE: return {1'b0, smoke_lim};
      LIM_CO:    return {1'b0, co_lim};
      default:   return '0;
    endcase
  endfunction

  task automatic reset_controller();
    has_th    = 1'b1;
    has_smoke = 1'b1;
    has_co    = 1'b1;
    mode      = MD_AUTO;
    dev_sel   = DEV_FAN;
    lim_sel   = LIM_PM25;
    pm25_lim  = PM25_LIMIT_RST;
    temp_lim  = TEMP_LIMIT_RST;
    hum_lim   = HUM_LIMIT_RST;
    smoke_lim = SMOKE_LIMIT_RST;
    co_lim    = CO_LIMIT_RST;
    pm25_rd   = '0;
    temp_rd   = '0;
    hum_rd    = '0;
    smoke_rd  = '0;
    co_rd     = '0;
    fan       = 1'b0;
    buzzer    = 1'b0;
    light     = 1'b0;
    alarm     = 1'b0;
  endtask

  task automatic drive_device(input logic on);
    case (dev_sel)
      DEV_FAN:    fan = on;
      DEV_BUZZER: buzzer = on;
      DEV_LIGHT:  light = on;
      default:    ;
    endcase
  endtask

  // Apply one event and return the status word the block should report after it.
  task automatic advance_controller(input in_item_t ev, output result_t st);
    logic       hot;
    logic       found;
    logic [2:0] nxt;
    case (ev.command)
      CMD_SAMPLE: begin
        pm25_rd = ev.pm25;
        if (has_th) begin
          temp_rd = ev.temp;
          hum_rd  = ev.humidity;
        end
        if (has_smoke) smoke_rd = ev.smoke;
        if (has_co) co_rd = ev.co;
      end
      CMD_TICK: begin
        if (mode == MD_AUTO) begin
          hot = pm25_rd > pm25_lim;
          if (has_th && (temp_rd > temp_lim || hum_rd > hum_lim)) hot = 1'b1;
          if (has_smoke && smoke_rd > smoke_lim) hot = 1'b1;
          if (has_co && co_rd > co_lim) hot = 1'b1;
          alarm  = hot;
          fan    = hot;
          buzzer = hot;
          light  = hot;
        end
      end
      CMD_MODE_KEY: begin
        case (mode)
          MD_AUTO: begin
            mode    = MD_MANUAL;
            dev_sel = DEV_FAN;
          end
          MD_MANUAL: begin
            mode    = MD_THRESH;
            lim_sel = LIM_PM25;
          end
          default: mode = MD_AUTO;
        endcase
      end
      CMD_SELECT_KEY: begin
        if (mode == MD_MANUAL) begin
          dev_sel = (dev_sel >= DEV_LIGHT) ? DEV_FAN : dev_sel + 2'd1;
        end else if (mode == MD_THRESH) begin
          // next fitted limit, pm25 is always there so the search ends
          nxt   = lim_sel;
          found = 1'b0;
          for (int i = 0; i < LIM_COUNT; i++) begin
            if (!found) begin
              nxt   = (nxt >= LIM_CO) ? LIM_PM25 : nxt + 3'd1;
              found = limit_fitted(nxt);
            end
          end
          lim_sel = found ? nxt : LIM_PM25;
        end
      end
      CMD_PLUS_KEY: begin
        if (mode == MD_MANUAL) begin
          drive_device(1'b1);
        end else if (mode == MD_THRESH) begin
          // increments wrap within each limit's width
          case (lim_sel)
            LIM_PM25:  pm25_lim  = pm25_lim + PM25_STEP;
            LIM_TEMP:  temp_lim  = temp_lim + TEMP_STEP;
            LIM_HUM:   hum_lim   = hum_lim + HUM_STEP;
            LIM_SMOKE: smoke_lim = smoke_lim + SMOKE_STEP;
            LIM_CO:    co_lim    = co_lim + CO_STEP;
            default:   ;
          endcase
        end
      end
      CMD_MINUS_KEY: begin
        if (mode == MD_MANUAL) begin
          drive_device(1'b0);
        end else if (mode == MD_THRESH) begin
          case (lim_sel)
            LIM_PM25:  if (pm25_lim >= PM25_STEP) pm25_lim = pm25_lim - PM25_STEP;
            LIM_TEMP:  if (temp_lim > TEMP_LIMIT_FLOOR) temp_lim = temp_lim - TEMP_STEP;
            LIM_HUM:   if (hum_lim >= HUM_STEP) hum_lim = hum_lim - HUM_STEP;
            LIM_SMOKE: if (smoke_lim >= SMOKE_STEP) smoke_lim = smoke_lim - SMOKE_STEP;
            LIM_CO:    if (co_lim >= CO_STEP) co_lim = co_lim - CO_STEP;
            default:   ;
          endcase
        end
      end
      default: ;
    endcase
    st                   = '0;
    st.fan_on            = fan;
    st.buzz_on           = buzzer;
    st.lamp_on           = light;
    st.alarm_hit         = alarm;
    st.mode_now          = mode;
    st.device_selected   = dev_sel;
    st.limit_selected    = lim_sel;
    st.limit_value       = selected_limit();
    st.telemetry_request = (ev.command == CMD_SAMPLE);
  endtask

  task automatic check_field(input string field, input logic [16:0] want,
                             input logic [16:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s expected %0h got %0h", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    result_t  got, want, nxt;
    in_item_t ev;
    if (rst) begin
      reset_controller();
      status_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_HAS_TEMP_HUMIDITY: has_th = cfg_data;
          CFG_HAS_SMOKE:         has_smoke = cfg_data;
          CFG_HAS_CO:            has_co = cfg_data;
          default:               ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (status_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: status %0h with no event outstanding", $time, got);
        end else begin
          want = status_q.pop_front();
          check_field("fan_on", 17'(want.fan_on), 17'(got.fan_on));
          check_field("buzz_on", 17'(want.buzz_on), 17'(got.buzz_on));
          check_field("lamp_on", 17'(want.lamp_on), 17'(got.lamp_on));
          check_field("alarm_hit", 17'(want.alarm_hit), 17'(got.alarm_hit));
          check_field("mode_now", 17'(want.mode_now), 17'(got.mode_now));
          check_field("device_selected", 17'(want.device_selected),
                      17'(got.device_selected));
          check_field("limit_selected", 17'(want.limit_selected),
                      17'(got.limit_selected));
          check_field("limit_value", want.limit_value, got.limit_value);
          check_field("telemetry_request", 17'(want.telemetry_request),
                      17'(got.telemetry_request));
          check_field("pad", 17'(want.pad), 17'(got.pad));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        ev = in_item_t'({s_axis_tuser, s_axis_tdata});
        advance_controller(ev, nxt);
        status_q.push_back(nxt);
      end
    end
    pending = status_q.size();
  end

endmodule

/* bench/air_quality_alarm_controller_tb.sv */
// Stimulus, reset, handshake pacing and final verdict for the alarm controller.
module air_quality_alarm_controller_tb;
  import aqac_pkg::*;

  localparam logic [2:0] CMD_SPARE_6 = 3'd6;
  localparam logic [2:0] CMD_SPARE_7 = 3'd7;
  localparam int HOLD_CYCLES = 64;
  localparam int STUCK_LIMIT = 3000;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [IN_USER_W-1:0]  s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [1:0]            cfg_index = '0;
  logic                  cfg_data = 1'b0;

  int    mismatches;
  int    pending;
  int    items_sent = 0;
  int    send_idle_pct = 0;
  int    recv_stall_pct = 0;
  int    stuck_cycles = 0;
  bit    hold_off_req = 1'b0;
  mode_t tb_mode = MD_AUTO;

  air_quality_alarm_controller u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  aqac_status_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .mismatches    (mismatches),
    .pending       (pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // status consumer: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  function automatic logic [63:0] pack_sample(input logic [15:0] pm25, input logic [7:0] temp,
                                              input logic [7:0] hum, input logic [15:0] smoke,
                                              input logic [15:0] co);
    return {co, smoke, hum, temp, pm25};
  endfunction

  function automatic logic [63:0] noise();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [15:0] pick_reading16();
    case ($urandom_range(3))
      0:       return '0;
      1:       return '1;
      2:       return 16'($urandom_range(600));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [63:0] random_sample();
    logic [7:0] temp, hum;
    case ($urandom_range(3))
      0:       temp = 8'h80;
      1:       temp = 8'h7f;
      2:       temp = 8'($urandom_range(20, 50));
      default: temp = 8'($urandom);
    endcase
    hum = $urandom_range(1) ? 8'($urandom_range(70, 90)) : 8'($urandom);
    return pack_sample(pick_reading16(), temp, hum, pick_reading16(), pick_reading16());
  endfunction

  // Offer one event; returns at the edge where the transaction completes, valid left high.
  task automatic send_event(input logic [2:0] cmd, input logic [63:0] data);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= data;
    do @(negedge clk); while (!s_axis_tready);
    @(posedge clk);
    items_sent++;
    if (cmd == CMD_MODE_KEY) begin
      case (tb_mode)
        MD_AUTO:   tb_mode = MD_MANUAL;
        MD_MANUAL: tb_mode = MD_THRESH;
        default:   tb_mode = MD_AUTO;
      endcase
    end
  endtask

  // Stop offering and wait until every status word has come back.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
  endtask

  task automatic set_sensors(input logic th, input logic smoke, input logic co);
    write_reg(CFG_HAS_TEMP_HUMIDITY, th);
    write_reg(CFG_HAS_SMOKE, smoke);
    write_reg(CFG_HAS_CO, co);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_events(input int n_items);
    int         stop_at;
    int         pick;
    int         reps;
    logic [2:0] key;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 25) begin
        send_event(CMD_SAMPLE, random_sample());
        if ($urandom_range(1)) send_event(CMD_TICK, noise());
      end else if (pick < 37) begin
        send_event(CMD_TICK, noise());
      end else if (pick < 47) begin
        send_event(CMD_MODE_KEY, noise());
      end else if (pick < 59) begin
        send_event(CMD_SELECT_KEY, noise());
      end else if (pick < 90) begin
        // long runs in threshold mode reach the temperature and humidity limit wraps and the lower guards
        key  = $urandom_range(1) ? CMD_PLUS_KEY : CMD_MINUS_KEY;
        reps = (tb_mode == MD_THRESH && $urandom_range(3) == 0) ?
               $urandom_range(60, 110) : $urandom_range(1, 6);
        repeat (reps) send_event(key, noise());
      end else if (pick < 95) begin
        send_event($urandom_range(1) ? CMD_SPARE_6 : CMD_SPARE_7, noise());
      end else begin
        send_event(3'($urandom_range(7)), noise());
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes, every command, mode walk, spare codes
    send_event(CMD_SAMPLE, pack_sample('1, 8'h80, '1, '1, '1));
    send_event(CMD_TICK, noise());
    send_event(CMD_SAMPLE, pack_sample('0, 8'h7f, '0, '0, '0));
    send_event(CMD_TICK, noise());
    send_event(CMD_SAMPLE, pack_sample('0, 8'h80, '0, '0, '0));
    send_event(CMD_TICK, noise());
    send_event(CMD_SELECT_KEY, noise());
    send_event(CMD_PLUS_KEY, noise());
    send_event(CMD_MINUS_KEY, noise());
    send_event(CMD_MODE_KEY, noise());
    send_event(CMD_PLUS_KEY, noise());
    send_event(CMD_SELECT_KEY, noise());
    send_event(CMD_PLUS_KEY, noise());
    send_event(CMD_SELECT_KEY, noise());
    send_event(CMD_PLUS_KEY, noise());
    send_event(CMD_SELECT_KEY, noise());
    send_event(CMD_MINUS_KEY, noise());
    send_event(CMD_TICK, noise());
    send_event(CMD_MODE_KEY, noise());
    send_event(CMD_MINUS_KEY, noise());
    send_event(CMD_PLUS_KEY, noise());
    for (int i = 0; i < LIM_COUNT; i++) begin
      send_event(CMD_SELECT_KEY, noise());
      send_event($urandom_range(1) ? CMD_PLUS_KEY : CMD_MINUS_KEY, noise());
    end
    send_event(CMD_SPARE_6, noise());
    send_event(CMD_SPARE_7, noise());
    send_event(CMD_MODE_KEY, noise());

    // full rate, with a long consumer hold-off so the input backs up
    hold_off_req = 1'b1;
    random_events(100);
    drain();

    set_sensors(1'b0, 1'b0, 1'b0);
    send_idle_pct  = 86;
    recv_stall_pct = 0;
    random_events(100);
    drain();

    set_sensors(1'b1, 1'b0, 1'b1);
    send_idle_pct  = 0;
    recv_stall_pct = 86;
    random_events(100);
    drain();

    set_sensors(1'b0, 1'b1, 1'b0);
    send_idle_pct  = 37;
    recv_stall_pct = 37;
    random_events(100);
    drain();

    set_sensors(1'b1, 1'b1, 1'b1);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    random_events(100);
    drain();

    repeat (8) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
